/* design/sha1_pkg.sv */
// Package for the SHA-1 stream hasher: constants, command and status types.
// Used by the controller, the datapath and the top level.
`default_nettype none
package sha1_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned Rounds = 80;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hefcdab89;
	localparam logic [31:0] H2 = 32'h98badcfe;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hc3d2e1f0;
	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;
	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LengthPos = 6'd56;

	typedef struct packed {
		logic       put;       // write put_byte at fill position
		logic [7:0] put_byte;
		logic       count_msg; // bump message length
		logic       snap_len;  // capture bit length for padding
		logic       write_len; // place length words 14 and 15
		logic       comp_start;
		logic       round;     // run one compression round
		logic       comp_end;  // fold round vars into chain
		logic       restart;
	} sha1_cmd_t;

	typedef struct packed {
		logic       full;      // fill position is 63 before put
		logic [5:0] fill;
		logic       last_round;
	} sha1_sts_t;
endpackage
`default_nettype wire

/* design/sha1_datapath.sv */
// SHA-1 datapath: block buffer, message schedule, round logic, chain words.
// Depends on sha1_pkg; driven by sha1_ctrl.
`default_nettype none
module sha1_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha1_pkg::sha1_cmd_t cmd,
	output sha1_pkg::sha1_sts_t    sts,
	output logic [31:0]            h_out [5]
);
	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] v_q [5];
	logic [5:0]  fill_q;
	logic [63:0] msg_q;
	logic [63:0] bits_q;
	logic [6:0]  rnd_q;
	logic [3:0]  ti;
	logic [31:0] wx, wt, f, kc, tmp;
	logic [4:0]  sh;

	assign ti = rnd_q[3:0];
	assign wx = w_q[ti + 4'd13] ^ w_q[ti + 4'd8] ^ w_q[ti + 4'd2] ^ w_q[ti];
	assign wt = (rnd_q >= 7'd16) ? {wx[30:0], wx[31]} : w_q[ti];
	assign sh = {~fill_q[1:0], 3'b000};

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
			kc = sha1_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			kc = sha1_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
			kc = sha1_pkg::K2;
		end else begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			kc = sha1_pkg::K3;
		end
	end
	assign tmp = {v_q[0][26:0], v_q[0][31:27]} + f + v_q[4] + wt + kc;

	assign sts.full = (fill_q == 6'd63);
	assign sts.fill = fill_q;
	assign sts.last_round = (rnd_q == 7'(sha1_pkg::Rounds - 1));
	assign h_out = h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= sha1_pkg::H0;
			h_q[1] <= sha1_pkg::H1;
			h_q[2] <= sha1_pkg::H2;
			h_q[3] <= sha1_pkg::H3;
			h_q[4] <= sha1_pkg::H4;
			fill_q <= '0;
			msg_q <= '0;
			rnd_q <= '0;
		end else begin
			if (cmd.count_msg) begin
				msg_q <= msg_q + 64'd1;
			end
			if (cmd.put) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.comp_start) begin
				rnd_q <= '0;
			end else if (cmd.round) begin
				rnd_q <= rnd_q + 7'd1;
			end
			if (cmd.comp_end) begin
				for (int k = 0; k < 5; k++) begin
					h_q[k] <= h_q[k] + v_q[k];
				end
			end
			if (cmd.restart) begin
				h_q[0] <= sha1_pkg::H0;
				h_q[1] <= sha1_pkg::H1;
				h_q[2] <= sha1_pkg::H2;
				h_q[3] <= sha1_pkg::H3;
				h_q[4] <= sha1_pkg::H4;
				fill_q <= '0;
				msg_q <= '0;
				rnd_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.snap_len) begin
			bits_q <= {msg_q[60:0], 3'b000};
		end
		if (cmd.put) begin
			if (fill_q[1:0] == 2'd0) begin
				w_q[fill_q[5:2]] <= {24'd0, cmd.put_byte} << sh;
			end else begin
				w_q[fill_q[5:2]] <= w_q[fill_q[5:2]] | ({24'd0, cmd.put_byte} << sh);
			end
		end
		if (cmd.write_len) begin
			w_q[14] <= bits_q[63:32];
			w_q[15] <= bits_q[31:0];
		end
		if (cmd.comp_start) begin
			v_q <= h_q;
		end else if (cmd.round) begin
			if (rnd_q >= 7'd16) begin
				w_q[ti] <= wt;
			end
			v_q[4] <= v_q[3];
			v_q[3] <= v_q[2];
			v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
			v_q[1] <= v_q[0];
			v_q[0] <= tmp;
		end
	end
endmodule
`default_nettype wire

/* design/sha1_ctrl.sv */
// SHA-1 controller: input handshake, padding sequence, compression control.
// Depends on sha1_pkg; commands sha1_datapath.
`default_nettype none
module sha1_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              has_byte,
	input  wire logic              finish,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sha1_pkg::sha1_cmd_t    cmd,
	input  wire sha1_pkg::sha1_sts_t sts
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_INIT  = 7'b0000010,
		S_ROUND = 7'b0000100,
		S_FOLD  = 7'b0001000,
		S_PAD   = 7'b0010000,
		S_LEN   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   fin_q, fin_d;   // finishing: after compression go to pad/out
	logic   padded_q, padded_d; // 0x80 already placed
	logic   lenblk_q, lenblk_d; // current compression is the length block
	logic   acc;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign acc = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		fin_d = fin_q;
		padded_d = padded_q;
		lenblk_d = lenblk_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					cmd.put = has_byte;
					cmd.put_byte = data_byte;
					cmd.count_msg = has_byte;
					fin_d = finish;
					padded_d = 1'b0;
					lenblk_d = 1'b0;
					if (has_byte && sts.full) begin
						state_d = S_INIT;
					end else if (finish) begin
						state_d = S_PAD;
					end
				end
			end
			S_PAD: begin
				cmd.snap_len = !padded_q;
				if (sts.fill == sha1_pkg::LengthPos && padded_q) begin
					cmd.write_len = 1'b1;
					lenblk_d = 1'b1;
					state_d = S_INIT;
				end else begin
					cmd.put = 1'b1;
					cmd.put_byte = padded_q ? 8'd0 : sha1_pkg::PadByte;
					padded_d = 1'b1;
					if (sts.full) begin
						state_d = S_INIT;
					end
				end
			end
			S_INIT: begin
				cmd.comp_start = 1'b1;
				state_d = S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (sts.last_round) begin
					state_d = S_FOLD;
				end
			end
			S_FOLD: begin
				cmd.comp_end = 1'b1;
				if (lenblk_q) begin
					state_d = S_OUT;
				end else if (fin_q) begin
					state_d = S_PAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LEN: begin
				state_d = S_IDLE;
			end
			S_OUT: begin
				if (out_ready) begin
					cmd.restart = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fin_q <= 1'b0;
			padded_q <= 1'b0;
			lenblk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fin_q <= fin_d;
			padded_q <= padded_d;
			lenblk_q <= lenblk_d;
		end
	end
endmodule
`default_nettype wire

/* design/sha1_stream_hasher_top.sv */
// Top level of the SHA-1 stream hasher: controller plus datapath.
// Depends on sha1_pkg, sha1_ctrl and sha1_datapath.
//
// Input channel (in_valid/in_ready) carries one item per transfer: an
// optional message byte (data_byte when has_byte is 1) and a finish flag.
// An item that neither completes a 64-byte block nor carries finish
// leaves the block idle and ready. The 64th byte of a block starts a
// compression (load step, rounds, fold step) before the next transfer.
// An item with finish pads the block one byte per cycle, appends the bit
// length, compresses (twice if the length does not fit) and presents the
// digest on digest_word0..4 with out_valid. The digest holds until the
// receiver takes it with out_ready; meanwhile no input is accepted.
// After the digest transfer the chain words, byte count and fill position
// return to their initial values for the next message. Sustained rate is
// set by the one-round-per-cycle compression, which takes no input.
// Reset (arst_n low) returns the block to its initial, idle state.
`default_nettype none
module sha1_stream_hasher_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        finish,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word0,
	output logic [31:0]      digest_word1,
	output logic [31:0]      digest_word2,
	output logic [31:0]      digest_word3,
	output logic [31:0]      digest_word4
);
	sha1_pkg::sha1_cmd_t cmd;
	sha1_pkg::sha1_sts_t sts;
	logic [31:0] h [5];

	sha1_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .has_byte(has_byte), .finish(finish),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	sha1_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .h_out(h)
	);

	assign digest_word0 = h[0];
	assign digest_word1 = h[1];
	assign digest_word2 = h[2];
	assign digest_word3 = h[3];
	assign digest_word4 = h[4];
endmodule
`default_nettype wire

/* sim/sha1_stream_hasher_top_tb.sv */
// Self-checking testbench for the SHA-1 stream hasher top level.
// Depends on sha1_pkg for the initial chain words and round constants.
// Digests are predicted in software and compared per transfer.
`default_nettype none
module sha1_stream_hasher_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       fin;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] w0, w1, w2, w3, w4;
	} digest_t;

	typedef struct {
		msg_item_t item;
		logic      known;
		digest_t   digest;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] data_byte;
	logic has_byte;
	logic finish;
	logic out_valid;
	logic out_ready;
	logic [31:0] digest_word0, digest_word1, digest_word2, digest_word3, digest_word4;

	logic [31:0] chain [5];
	logic [31:0] sched [16];
	logic [6:0]  fill;
	logic [63:0] msg_len;
	digest_t     pending_digests [$];
	int          failures;
	int          items_sent;
	bit          rx_long_stall;
	stim_row_t   rows [$];

	localparam digest_t EmptyDigest = {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef,
		32'h95601890, 32'hafd80709};
	localparam digest_t AbcDigest = {32'ha9993e36, 32'h4706816a, 32'hba3e2571,
		32'h7850c26c, 32'h9cd0d89d};

	sha1_stream_hasher_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .has_byte(has_byte), .finish(finish),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word0(digest_word0), .digest_word1(digest_word1),
		.digest_word2(digest_word2), .digest_word3(digest_word3),
		.digest_word4(digest_word4)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("sha1_stream_hasher_top_tb: errors");
		$finish;
	end

	function automatic logic [31:0] rotl32(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic restart_hash();
		chain[0] = sha1_pkg::H0;
		chain[1] = sha1_pkg::H1;
		chain[2] = sha1_pkg::H2;
		chain[3] = sha1_pkg::H3;
		chain[4] = sha1_pkg::H4;
		fill = '0;
		msg_len = '0;
	endtask

	task automatic compress_block();
		logic [31:0] a, b, c, d, e, f, k, w, t;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (int r = 0; r < sha1_pkg::Rounds; r++) begin
			if (r >= 16) begin
				sched[r & 15] = rotl32(sched[(r + 13) & 15] ^ sched[(r + 8) & 15]
					^ sched[(r + 2) & 15] ^ sched[r & 15], 1);
			end
			w = sched[r & 15];
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = sha1_pkg::K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = sha1_pkg::K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1_pkg::K2;
			end else begin
				f = b ^ c ^ d;
				k = sha1_pkg::K3;
			end
			t = rotl32(a, 5) + f + e + w + k;
			e = d;
			d = c;
			c = rotl32(b, 30);
			b = a;
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
	endtask

	task automatic absorb_byte(logic [7:0] v);
		int pos;
		int sh;
		pos = fill[5:0];
		sh = (3 - (pos & 3)) * 8;
		if ((pos & 3) == 0) begin
			sched[pos >> 2] = 32'(v) << sh;
		end else begin
			sched[pos >> 2] |= 32'(v) << sh;
		end
		fill = 7'(pos + 1);
		if (fill >= 64) begin
			compress_block();
			fill = '0;
		end
	endtask

	task automatic predict_digest(msg_item_t it, output logic produced, output digest_t dg);
		logic [63:0] bits;
		produced = 1'b0;
		dg = '0;
		if (it.has) begin
			msg_len++;
			absorb_byte(it.data);
		end
		if (it.fin) begin
			bits = msg_len << 3;
			absorb_byte(sha1_pkg::PadByte);
			while (fill != sha1_pkg::LengthPos) absorb_byte(8'h00);
			sched[14] = bits[63:32];
			sched[15] = bits[31:0];
			compress_block();
			dg = {chain[0], chain[1], chain[2], chain[3], chain[4]};
			produced = 1'b1;
			restart_hash();
		end
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 120);
	endfunction

	task automatic send_item(msg_item_t it, logic known, digest_t ref_dg);
		logic produced;
		digest_t dg;
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= it.data;
		has_byte <= it.has;
		finish <= it.fin;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		predict_digest(it, produced, dg);
		if (produced) begin
			if (known && dg != ref_dg) begin
				$error("predictor digest mismatch: expected %h actual %h", ref_dg, dg);
				failures++;
			end
			pending_digests.push_back(dg);
		end
	endtask

	function automatic msg_item_t mk(logic [7:0] d, logic h, logic f);
		msg_item_t it;
		it.data = d;
		it.has = h;
		it.fin = f;
		return it;
	endfunction

	task automatic add_row(msg_item_t it, logic known = 1'b0, digest_t dg = '0);
		stim_row_t r;
		r.item = it;
		r.known = known;
		r.digest = dg;
		rows.push_back(r);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_digests.size() != 0);
	endtask

	task automatic send_random_message();
		int len;
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) len = $urandom_range(0, 20);
		else if (p < 85) len = $urandom_range(50, 70);
		else len = $urandom_range(110, 135);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) send_item(mk(8'($urandom), 1'b0, 1'b0), 1'b0, '0);
			send_item(mk(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(0, 1)),
				1'b0, '0);
		end
		if (fill != 0 || msg_len != 0 || len == 0) begin
			send_item(mk(8'($urandom), 1'b0, 1'b1), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (!rx_long_stall && $urandom_range(0, 40) == 0) rx_long_stall <= 1'b1;
		else if (rx_long_stall && $urandom_range(0, 15) == 0) rx_long_stall <= 1'b0;
		out_ready <= !rx_long_stall && ($urandom_range(0, 3) != 0);
		if (arst_n && out_valid && out_ready) begin
			if (pending_digests.size() == 0) begin
				$error("digest transfer with no message pending");
				failures++;
			end else begin
				digest_t e;
				e = pending_digests.pop_front();
				if (digest_word0 !== e.w0) begin
					$error("digest_word0 expected %h actual %h", e.w0, digest_word0);
					failures++;
				end
				if (digest_word1 !== e.w1) begin
					$error("digest_word1 expected %h actual %h", e.w1, digest_word1);
					failures++;
				end
				if (digest_word2 !== e.w2) begin
					$error("digest_word2 expected %h actual %h", e.w2, digest_word2);
					failures++;
				end
				if (digest_word3 !== e.w3) begin
					$error("digest_word3 expected %h actual %h", e.w3, digest_word3);
					failures++;
				end
				if (digest_word4 !== e.w4) begin
					$error("digest_word4 expected %h actual %h", e.w4, digest_word4);
					failures++;
				end
			end
		end
	end

	initial begin
		int lens [4];
		failures = 0;
		items_sent = 0;
		rx_long_stall = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		has_byte = 1'b0;
		finish = 1'b0;
		out_ready = 1'b0;
		lens = '{55, 56, 63, 64};
		restart_hash();
		for (int i = 0; i < 16; i++) sched[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message, empty items, finish with and without a byte.
		add_row(mk(8'h00, 1'b0, 1'b0));
		add_row(mk(8'hff, 1'b0, 1'b1), 1'b1, EmptyDigest);
		add_row(mk(8'h61, 1'b1, 1'b0));
		add_row(mk(8'hff, 1'b0, 1'b0));
		add_row(mk(8'h62, 1'b1, 1'b0));
		add_row(mk(8'h63, 1'b1, 1'b1), 1'b1, AbcDigest);
		add_row(mk(8'hff, 1'b1, 1'b1));
		add_row(mk(8'h00, 1'b1, 1'b0));
		add_row(mk(8'h00, 1'b0, 1'b1));
		foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].digest);

		// Lengths around the padding boundary and a full block.
		foreach (lens[j]) begin
			for (int i = 0; i < lens[j]; i++) begin
				send_item(mk(8'(i * 37), 1'b1, i == lens[j] - 1), 1'b0, '0);
			end
		end
		wait_drained();

		while (items_sent < 1950) begin
			send_random_message();
			if ($urandom_range(0, 25) == 0) wait_drained();
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (failures == 0) begin
			$display("sha1_stream_hasher_top_tb: clean");
		end else begin
			$display("sha1_stream_hasher_top_tb: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
